/* rtl/mdt_pkg.sv */
// shared types and constants for the multi-slot deadline timer
package mdt_pkg;

  localparam int TIME_W = 64;
  localparam int SLOT_W = 4;
  localparam int MASK_W = 16;

  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_ARM_ABS = 2'd1,
    ACT_ARM_REL = 2'd2,
    ACT_REMOVE  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPLY,
    ST_SCAN,
    ST_LAST,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic load;
    logic apply;
    logic scan_step;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } stat_t;

endpackage

/* rtl/mdt_dp.sv */
// datapath: deadline memory, slot marks, scan compare and result register
module mdt_dp #(
  parameter int USED  = 16,
  parameter int IDX_W = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mdt_pkg::cmd_t                cmd,
  output mdt_pkg::stat_t               stat,
  input  logic [1:0]                   in_action,
  input  logic [mdt_pkg::SLOT_W-1:0]   in_slot,
  input  logic [mdt_pkg::TIME_W-1:0]   in_time_value,
  input  logic [mdt_pkg::TIME_W-1:0]   in_now_us,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_status,
  output logic [mdt_pkg::MASK_W-1:0]   out_newly_fired,
  output logic [mdt_pkg::MASK_W-1:0]   out_signaled
);

  localparam int SLOT_CMP_W = mdt_pkg::SLOT_W + 1;

  logic [mdt_pkg::TIME_W-1:0] mem [USED];

  mdt_pkg::action_t           act_r;
  logic [mdt_pkg::SLOT_W-1:0] slot_r;
  logic [mdt_pkg::TIME_W-1:0] tval_r;
  logic [mdt_pkg::TIME_W-1:0] now_r;

  logic [USED-1:0]            armed_r, armed_nxt;
  logic [USED-1:0]            sig_r, sig_nxt;
  logic [USED-1:0]            fired_r, fired_nxt;
  logic                       status_r, status_nxt;

  logic [IDX_W-1:0]           cnt_r;
  logic                       cmp_en_r;
  logic [IDX_W-1:0]           cmp_idx_r;
  logic [mdt_pkg::TIME_W-1:0] rd_data_r;

  logic                       out_valid_r;
  logic                       out_status_r;
  logic [mdt_pkg::MASK_W-1:0] out_fired_r;
  logic [mdt_pkg::MASK_W-1:0] out_sig_r;

  logic                       in_range;
  logic [IDX_W-1:0]           slot_idx;
  logic                       is_arm;
  logic                       hit;
  logic [mdt_pkg::TIME_W-1:0] wdata;

  assign slot_idx = slot_r[IDX_W-1:0];
  assign in_range = {1'b0, slot_r} < SLOT_CMP_W'(USED);
  assign is_arm   = (act_r == mdt_pkg::ACT_ARM_ABS) || (act_r == mdt_pkg::ACT_ARM_REL);
  assign wdata    = (act_r == mdt_pkg::ACT_ARM_ABS) ? tval_r : now_r + tval_r;
  assign hit      = cmp_en_r && armed_r[cmp_idx_r] && !sig_r[cmp_idx_r] &&
                    (now_r >= rd_data_r);

  assign stat.scan_last = (cnt_r == IDX_W'(USED - 1));
  assign stat.out_free  = !out_valid_r || !out_stall;

  // beat capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= mdt_pkg::action_t'(in_action);
      slot_r <= in_slot;
      tval_r <= in_time_value;
      now_r  <= in_now_us;
    end
  end

  // deadline memory
  always_ff @(posedge clk) begin
    if (cmd.apply && is_arm && in_range) begin
      mem[slot_idx] <= wdata;
    end
    if (cmd.scan_step) begin
      rd_data_r <= mem[cnt_r];
    end
  end

  always_comb begin
    armed_nxt  = armed_r;
    sig_nxt    = sig_r;
    fired_nxt  = fired_r;
    status_nxt = status_r;
    if (cmd.load) begin
      fired_nxt  = '0;
      status_nxt = 1'b0;
    end
    if (cmd.apply) begin
      case (act_r)
        mdt_pkg::ACT_ARM_ABS, mdt_pkg::ACT_ARM_REL: begin
          if (in_range) begin
            armed_nxt[slot_idx] = 1'b1;
            sig_nxt[slot_idx]   = 1'b0;
          end
        end
        mdt_pkg::ACT_REMOVE: begin
          if (in_range && armed_r[slot_idx]) begin
            armed_nxt[slot_idx] = 1'b0;
            sig_nxt[slot_idx]   = 1'b0;
          end else begin
            status_nxt = 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (hit) begin
      sig_nxt[cmp_idx_r]   = 1'b1;
      fired_nxt[cmp_idx_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r  <= '0;
      sig_r    <= '0;
      cmp_en_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      armed_r  <= armed_nxt;
      sig_r    <= sig_nxt;
      cmp_en_r <= cmd.scan_step;
      if (cmd.load) begin
        cnt_r <= '0;
      end else if (cmd.scan_step) begin
        cnt_r <= cnt_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    fired_r   <= fired_nxt;
    status_r  <= status_nxt;
    cmp_idx_r <= cnt_r;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.publish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_status_r <= status_r;
      out_fired_r  <= mdt_pkg::MASK_W'(fired_r);
      out_sig_r    <= mdt_pkg::MASK_W'(armed_r & sig_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_newly_fired = out_fired_r;
  assign out_signaled    = out_sig_r;

endmodule

/* rtl/mdt_ctrl.sv */
// controller: sequences one beat through apply or scan and hands off the result
module mdt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic [1:0]     in_action,
  output logic           in_stall,
  input  mdt_pkg::stat_t stat,
  output mdt_pkg::cmd_t  cmd
);

  mdt_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mdt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      mdt_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_action == mdt_pkg::ACT_TICK) begin
            state_nxt = mdt_pkg::ST_SCAN;
          end else begin
            state_nxt = mdt_pkg::ST_APPLY;
          end
        end
      end
      mdt_pkg::ST_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = mdt_pkg::ST_RESULT;
      end
      mdt_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_nxt = mdt_pkg::ST_LAST;
        end
      end
      mdt_pkg::ST_LAST: begin
        state_nxt = mdt_pkg::ST_RESULT;
      end
      mdt_pkg::ST_RESULT: begin
        if (stat.out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = mdt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mdt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/multi_slot_deadline_timer_top.sv */
// top level of the multi-slot deadline timer
// A table of deadline timer slots, each with a 64-bit microsecond deadline,
// an armed mark and a sticky signaled mark. Every input beat gives exactly
// one result beat. Arm-absolute, arm-relative and remove beats go from
// accept to result through capture, apply and publish. A tick walks the
// deadline memory one slot per cycle through its single read port. Only
// slots 0..15 can be addressed by the 4-bit slot field, so larger tables
// keep no storage beyond sixteen slots. The result sits in an output
// register, so a new beat is taken while the last result still waits to
// be read; the block stalls its input only while a beat is in flight.
module multi_slot_deadline_timer_top #(
  parameter int TIMER_SLOTS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_action,
  input  logic [mdt_pkg::SLOT_W-1:0] in_slot,
  input  logic [mdt_pkg::TIME_W-1:0] in_time_value,
  input  logic [mdt_pkg::TIME_W-1:0] in_now_us,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_status,
  output logic [mdt_pkg::MASK_W-1:0] out_newly_fired,
  output logic [mdt_pkg::MASK_W-1:0] out_signaled
);

  // slots reachable by the slot field
  localparam int USED  = (TIMER_SLOTS < mdt_pkg::MASK_W) ? TIMER_SLOTS : mdt_pkg::MASK_W;
  localparam int IDX_W = (USED > 1) ? $clog2(USED) : 1;

  mdt_pkg::cmd_t  cmd;
  mdt_pkg::stat_t stat;

  // sequencer
  mdt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // storage, compare and result register
  mdt_dp #(
    .USED  (USED),
    .IDX_W (IDX_W)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_action       (in_action),
    .in_slot         (in_slot),
    .in_time_value   (in_time_value),
    .in_now_us       (in_now_us),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_newly_fired (out_newly_fired),
    .out_signaled    (out_signaled)
  );

endmodule
